FILE: rtl/spindle_speed_map_ramp_controller_macros.svh
// Assertion macros shared by the spindle controller RTL.
// Define NO_ASSERTIONS to compile them out; the including module needs aclk and aresetn.
`ifndef SPINDLE_SPEED_MAP_RAMP_CONTROLLER_MACROS_SVH
`define SPINDLE_SPEED_MAP_RAMP_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SSMR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define SSMR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SSMR_ASSERT_IMP(label, ante, cons, msg)

`define SSMR_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/ssmr_pkg.sv
// Shared types, codes and small arithmetic helpers for the spindle controller.
// No dependencies; used by every RTL module of the block.
package ssmr_pkg;

    localparam int MAP_POINTS_DEF = 5;
    localparam int PT_W           = 23;
    localparam int RPM_W          = 16;
    localparam int PCT_W          = 7;
    localparam int MS_W           = 16;
    localparam int TURN_W         = 32;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 5;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [PCT_W-1:0] DUTY_MAX = 7'd100;
    localparam logic [9:0]       LIN_RPM_MAX = 10'd1000;

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_CMD   = 3'd1;
    localparam logic [2:0] ACT_HALL  = 3'd2;
    localparam logic [2:0] ACT_CLR   = 3'd3;
    localparam logic [2:0] ACT_BRAKE = 3'd4;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_CW  = 2'd1;
    localparam logic [1:0] MODE_CCW = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MAP_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPINUP    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPINDOWN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POINT0    = 3'd3;

    localparam logic [MS_W-1:0] SPINUP_RST   = 16'd1000;
    localparam logic [MS_W-1:0] SPINDOWN_RST = 16'd2000;

    typedef enum logic [2:0] {
        K_TICK  = 3'd0,
        K_RUN   = 3'd1,
        K_STOP  = 3'd2,
        K_HALL  = 3'd3,
        K_CLR   = 3'd4,
        K_BRAKE = 3'd5,
        K_NOP   = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [1:0]       mode;
        logic [RPM_W-1:0] rpm;
    } item_t;

    typedef struct packed {
        logic [2:0]      map_count;
        logic [MS_W-1:0] spinup_ms;
        logic [MS_W-1:0] spindown_ms;
    } cfg_t;

    typedef struct packed {
        logic [15:0]       pwm_level;
        logic [PCT_W-1:0]  duty_now;
        logic              direction_out;
        logic              brake_out;
        logic              ramp_busy;
        logic [1:0]        mode_now;
        logic [TURN_W-1:0] turns;
    } res_t;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

    // min(rpm,1000)/10; 205/2048 is exact for values below 1029
    function automatic logic [PCT_W-1:0] lin_duty(input logic [RPM_W-1:0] rpm);
        logic [9:0]  r;
        logic [17:0] p;
        r = (rpm > 16'(LIN_RPM_MAX)) ? LIN_RPM_MAX : rpm[9:0];
        p = 18'(r) * 18'd205;
        return p[17:11];
    endfunction

    // duty*65535/100 as duty*ceil(655.35*2^11) >> 11, exact for duty up to 100
    function automatic logic [15:0] pwm_of(input logic [PCT_W-1:0] d);
        logic [27:0] p;
        p = 28'(d) * 28'd1342157;
        return p[26:11];
    endfunction

endpackage

FILE: rtl/ssmr_front.sv
// Front end: takes input words, classifies them, and queues them for the core.
// Depends on ssmr_pkg.
module ssmr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_action,
    input  logic [1:0]           s_command_mode,
    input  logic [15:0]          s_target_rpm,
    output ssmr_pkg::item_t      q_item,
    output logic                 q_valid,
    input  logic                 q_pop
);

    ssmr_pkg::item_t                  q_mem_reg [ssmr_pkg::QDEPTH];
    logic [ssmr_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [ssmr_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [ssmr_pkg::QCNT_W-1:0]      count_reg;
    logic [ssmr_pkg::QCNT_W-1:0]      count_next;
    ssmr_pkg::kind_t                  kind;
    logic                             push;

    always_comb begin
        case (s_action)
            ssmr_pkg::ACT_TICK: kind = ssmr_pkg::K_TICK;
            ssmr_pkg::ACT_CMD: begin
                if (s_command_mode == ssmr_pkg::MODE_OFF) begin
                    kind = ssmr_pkg::K_STOP;
                end else if (s_command_mode == ssmr_pkg::MODE_CW ||
                             s_command_mode == ssmr_pkg::MODE_CCW) begin
                    kind = ssmr_pkg::K_RUN;
                end else begin
                    kind = ssmr_pkg::K_NOP;
                end
            end
            ssmr_pkg::ACT_HALL:  kind = ssmr_pkg::K_HALL;
            ssmr_pkg::ACT_CLR:   kind = ssmr_pkg::K_CLR;
            ssmr_pkg::ACT_BRAKE: kind = ssmr_pkg::K_BRAKE;
            default:             kind = ssmr_pkg::K_NOP;
        endcase
    end

    assign s_ready = (count_reg != ssmr_pkg::QCNT_W'(ssmr_pkg::QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= '{kind: kind, mode: s_command_mode, rpm: s_target_rpm};
        end
    end

endmodule

FILE: rtl/ssmr_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ssmr_pkg for its widths; used by the core for interpolation and step wait.
module ssmr_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ssmr_pkg::DIV_NUM_W-1:0]    num,
    input  logic [ssmr_pkg::DIV_DEN_W-1:0]    den,
    output logic                              done,
    output logic [ssmr_pkg::DIV_NUM_W-1:0]    quot
);

    logic [ssmr_pkg::DIV_NUM_W-1:0] quo_reg;
    logic [ssmr_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [ssmr_pkg::DIV_DEN_W-1:0] den_reg;
    logic [ssmr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [ssmr_pkg::DIV_DEN_W:0]   shifted;
    logic [ssmr_pkg::DIV_DEN_W:0]   trial;
    logic                           fits;

    // remainder stays below den, so the shifted value fits one extra bit
    assign shifted = {rem_reg, quo_reg[ssmr_pkg::DIV_NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign trial   = shifted - {1'b0, den_reg};

    assign done = done_reg;
    assign quot = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == ssmr_pkg::DIV_CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ssmr_pkg::DIV_CNT_W'(ssmr_pkg::DIV_NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ssmr_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[ssmr_pkg::DIV_NUM_W-2:0], fits};
            rem_reg <= fits ? trial[ssmr_pkg::DIV_DEN_W-1:0]
                            : shifted[ssmr_pkg::DIV_DEN_W-1:0];
        end
    end

endmodule

FILE: rtl/ssmr_core.sv
// Back end: executes queued words, maps rpm to duty, runs the ramp and holds the result word.
// Depends on ssmr_pkg, ssmr_div and the assertion macro header.
`include "spindle_speed_map_ramp_controller_macros.svh"

module ssmr_core #(
    parameter int MAP_POINTS = ssmr_pkg::MAP_POINTS_DEF,
    parameter int PT_IDX_W   = (MAP_POINTS > 1) ? $clog2(MAP_POINTS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ssmr_pkg::item_t             q_item,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  ssmr_pkg::cfg_t              cfg,
    output logic [PT_IDX_W-1:0]         pt_addr,
    input  logic [ssmr_pkg::PT_W-1:0]   pt_rdata,
    output ssmr_pkg::res_t              m_res,
    output logic                        m_valid,
    input  logic                        m_ready
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_EXEC     = 10'b0000000010,
        S_MAP      = 10'b0000000100,
        S_SCAN_RD  = 10'b0000001000,
        S_SCAN_CMP = 10'b0000010000,
        S_MUL      = 10'b0000100000,
        S_MDIV     = 10'b0001000000,
        S_START    = 10'b0010000000,
        S_SDIV     = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } state_t;

    localparam logic [2:0] NPTS = 3'(MAP_POINTS);

    state_t                           state_reg;

    // ramp and output state
    logic [ssmr_pkg::PCT_W-1:0]       duty_reg;
    logic [ssmr_pkg::PCT_W-1:0]       goal_duty_reg;
    logic [ssmr_pkg::MS_W-1:0]        step_wait_reg;
    logic [ssmr_pkg::MS_W-1:0]        wait_count_reg;
    logic                             ramping_reg;
    logic                             brake_after_reg;
    logic [1:0]                       mode_reg;
    logic                             dir_reg;
    logic                             brake_reg;
    logic [ssmr_pkg::TURN_W-1:0]      turn_reg;
    logic                             m_valid_reg;

    // working registers of one word
    ssmr_pkg::item_t                  item_reg;
    logic [2:0]                       idx_reg;
    logic [ssmr_pkg::PT_W-1:0]        prev_reg;
    logic signed [24:0]               prod_reg;
    logic [ssmr_pkg::RPM_W-1:0]       span_abs_reg;
    logic                             span_neg_reg;
    logic [ssmr_pkg::PCT_W-1:0]       d0_reg;
    logic [ssmr_pkg::PCT_W-1:0]       goal_reg;
    ssmr_pkg::res_t                   res_reg;

    logic [2:0]                       n_pts;
    logic [ssmr_pkg::MS_W-1:0]        wc;
    logic [ssmr_pkg::RPM_W-1:0]       cur_rpm;
    logic [ssmr_pkg::PCT_W-1:0]       cur_duty;
    logic [ssmr_pkg::RPM_W-1:0]       prev_rpm;
    logic [ssmr_pkg::PCT_W-1:0]       prev_duty;
    logic signed [16:0]               span;
    logic signed [16:0]               rpm_diff;
    logic signed [7:0]                duty_diff;
    logic signed [24:0]               prod_c;
    logic signed [24:0]               prod_abs;
    logic signed [24:0]               q_signed;
    logic signed [24:0]               interp;
    logic [ssmr_pkg::PCT_W-1:0]       interp_pct;
    logic [ssmr_pkg::MS_W-1:0]        ramp_ms;
    logic [ssmr_pkg::PCT_W-1:0]       steps;
    logic                             is_stop;
    logic                             slot_free;

    logic                             div_start;
    logic [ssmr_pkg::DIV_NUM_W-1:0]   div_num;
    logic [ssmr_pkg::DIV_DEN_W-1:0]   div_den;
    logic                             div_done;
    logic [ssmr_pkg::DIV_NUM_W-1:0]   div_quot;

    assign n_pts     = (cfg.map_count > NPTS) ? NPTS : cfg.map_count;
    assign pt_addr   = idx_reg[PT_IDX_W-1:0];
    assign slot_free = !m_valid_reg || m_ready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && slot_free;
    assign m_valid   = m_valid_reg;
    assign m_res     = res_reg;

    assign wc = (wait_count_reg != '0) ? (wait_count_reg - 1'b1) : '0;

    assign cur_rpm   = pt_rdata[15:0];
    assign cur_duty  = pt_rdata[22:16];
    assign prev_rpm  = prev_reg[15:0];
    assign prev_duty = prev_reg[22:16];
    assign span      = $signed({1'b0, cur_rpm}) - $signed({1'b0, prev_rpm});
    assign rpm_diff  = $signed({1'b0, item_reg.rpm}) - $signed({1'b0, prev_rpm});
    assign duty_diff = $signed({1'b0, cur_duty}) - $signed({1'b0, prev_duty});
    assign prod_c    = 25'(duty_diff) * 25'(rpm_diff);
    assign prod_abs  = prod_reg[24] ? -prod_reg : prod_reg;

    // truncation toward zero: divide magnitudes, then restore the sign
    assign q_signed  = (prod_reg[24] ^ span_neg_reg) ? -$signed({1'b0, div_quot})
                                                     : $signed({1'b0, div_quot});
    assign interp    = $signed({18'd0, d0_reg}) + q_signed;
    assign interp_pct = interp[24] ? '0 :
                        (interp > 25'sd100) ? ssmr_pkg::DUTY_MAX : interp[6:0];

    assign is_stop = (item_reg.kind == ssmr_pkg::K_STOP);
    assign ramp_ms = is_stop ? cfg.spindown_ms : cfg.spinup_ms;
    assign steps   = (duty_reg > goal_reg) ? (duty_reg - goal_reg) : (goal_reg - duty_reg);

    assign div_start = (state_reg == S_MUL) ||
                       ((state_reg == S_START) && (steps != '0) && (ramp_ms != '0));
    assign div_num   = (state_reg == S_MUL) ? prod_abs[23:0]
                                            : ssmr_pkg::DIV_NUM_W'(ramp_ms);
    assign div_den   = (state_reg == S_MUL) ? span_abs_reg
                                            : ssmr_pkg::DIV_DEN_W'(steps);

    ssmr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            duty_reg        <= '0;
            goal_duty_reg   <= '0;
            step_wait_reg   <= '0;
            wait_count_reg  <= '0;
            ramping_reg     <= 1'b0;
            brake_after_reg <= 1'b0;
            mode_reg        <= ssmr_pkg::MODE_OFF;
            dir_reg         <= 1'b0;
            brake_reg       <= 1'b1;
            turn_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_EMIT;
                    case (item_reg.kind)
                        ssmr_pkg::K_TICK: begin
                            if (ramping_reg) begin
                                if (wc == '0) begin
                                    if (duty_reg == goal_duty_reg) begin
                                        ramping_reg     <= 1'b0;
                                        wait_count_reg  <= '0;
                                        brake_after_reg <= 1'b0;
                                        if (brake_after_reg) begin
                                            brake_reg <= 1'b1;
                                        end
                                    end else begin
                                        duty_reg <= (duty_reg < goal_duty_reg) ?
                                                    duty_reg + 1'b1 : duty_reg - 1'b1;
                                        wait_count_reg <= step_wait_reg;
                                    end
                                end else begin
                                    wait_count_reg <= wc;
                                end
                            end
                        end
                        ssmr_pkg::K_RUN: begin
                            mode_reg  <= item_reg.mode;
                            brake_reg <= 1'b0;
                            dir_reg   <= (item_reg.mode == ssmr_pkg::MODE_CW);
                            state_reg <= S_MAP;
                        end
                        ssmr_pkg::K_STOP: begin
                            mode_reg  <= ssmr_pkg::MODE_OFF;
                            state_reg <= S_START;
                        end
                        ssmr_pkg::K_HALL: turn_reg <= turn_reg + 1'b1;
                        ssmr_pkg::K_CLR:  turn_reg <= '0;
                        ssmr_pkg::K_BRAKE: begin
                            duty_reg        <= '0;
                            goal_duty_reg   <= '0;
                            brake_reg       <= 1'b1;
                            ramping_reg     <= 1'b0;
                            brake_after_reg <= 1'b0;
                            wait_count_reg  <= '0;
                        end
                        default: ;
                    endcase
                end
                S_MAP: begin
                    if (n_pts == '0 || item_reg.rpm == '0 || n_pts == 3'd1) begin
                        state_reg <= S_START;
                    end else begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    if (item_reg.rpm <= cur_rpm) begin
                        state_reg <= (span == '0) ? S_START : S_MUL;
                    end else if (idx_reg == n_pts - 1'b1) begin
                        state_reg <= S_START;
                    end else begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_MUL: state_reg <= S_MDIV;
                S_MDIV: begin
                    if (div_done) begin
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    goal_duty_reg   <= goal_reg;
                    brake_after_reg <= is_stop;
                    if (steps == '0 || ramp_ms == '0) begin
                        duty_reg        <= goal_reg;
                        ramping_reg     <= 1'b0;
                        wait_count_reg  <= '0;
                        brake_after_reg <= 1'b0;
                        if (is_stop) begin
                            brake_reg <= 1'b1;
                        end
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (div_done) begin
                        state_reg <= S_EMIT;
                        if (div_quot == '0) begin
                            // ramp time shorter than the step count: jump at once
                            duty_reg        <= goal_duty_reg;
                            ramping_reg     <= 1'b0;
                            wait_count_reg  <= '0;
                            brake_after_reg <= 1'b0;
                            if (brake_after_reg) begin
                                brake_reg <= 1'b1;
                            end
                        end else begin
                            step_wait_reg  <= div_quot[ssmr_pkg::MS_W-1:0];
                            wait_count_reg <= div_quot[ssmr_pkg::MS_W-1:0];
                            ramping_reg    <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    item_reg <= q_item;
                    idx_reg  <= '0;
                end
            end
            S_EXEC: begin
                goal_reg <= '0;
            end
            S_MAP: begin
                // point zero has been read during the previous cycle
                prev_reg <= pt_rdata;
                idx_reg  <= 3'd1;
                if (n_pts == '0) begin
                    goal_reg <= ssmr_pkg::lin_duty(item_reg.rpm);
                end else begin
                    goal_reg <= ssmr_pkg::clamp_pct(cur_duty);
                end
            end
            S_SCAN_CMP: begin
                if (item_reg.rpm <= cur_rpm) begin
                    goal_reg     <= ssmr_pkg::clamp_pct(prev_duty);
                    prod_reg     <= prod_c;
                    span_neg_reg <= span[16];
                    span_abs_reg <= span[16] ? 16'(-span) : span[15:0];
                    d0_reg       <= prev_duty;
                end else begin
                    goal_reg <= ssmr_pkg::clamp_pct(cur_duty);
                    prev_reg <= pt_rdata;
                    idx_reg  <= idx_reg + 1'b1;
                end
            end
            S_MDIV: begin
                if (div_done) begin
                    goal_reg <= interp_pct;
                end
            end
            S_EMIT: begin
                res_reg.pwm_level     <= ssmr_pkg::pwm_of(duty_reg);
                res_reg.duty_now      <= duty_reg;
                res_reg.direction_out <= dir_reg;
                res_reg.brake_out     <= brake_reg;
                res_reg.ramp_busy     <= ramping_reg;
                res_reg.mode_now      <= mode_reg;
                res_reg.turns         <= turn_reg;
            end
            default: ;
        endcase
    end

    `SSMR_ASSERT_IMP(a_duty_range, 1'b1, duty_reg <= ssmr_pkg::DUTY_MAX, "duty above 100")
    `SSMR_ASSERT_IMP(a_ramp_wait, ramping_reg, step_wait_reg != '0 && wait_count_reg != '0 && wait_count_reg <= step_wait_reg, "ramp wait counter out of range")
    `SSMR_ASSERT_IMP(a_ramp_no_brake, ramping_reg, !brake_reg, "brake engaged while ramping")
    `SSMR_ASSERT_IMP(a_div_owner, div_done, state_reg == S_MDIV || state_reg == S_SDIV, "divider result with no waiting state")
    `SSMR_ASSERT_NXT(a_emit_valid, state_reg == S_EMIT, m_valid_reg, "result word not presented")

endmodule

FILE: rtl/spindle_speed_map_ramp_controller.sv
// Top level of the spindle speed map and ramp controller: APB registers, map point store,
// front queue and execution core. Depends on ssmr_pkg, ssmr_front and ssmr_core.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_action, s_command_mode, s_target_rpm
//  m_        out        m_valid/m_ready    m_pwm_level .. m_turns (one word per input)
//  apb       in         psel/penable       paddr, pwdata, prdata (pready tied high)
//
// Tick, hall, reset-turns and brake words pass via S_EXEC and S_EMIT to the result register.
// A mode command may also scan the map points and run up to two serial divides
// (interpolation and step wait each use the shared 24-step divider).
// Reset needs no clearing pass; map points read as zero until written (valid bits).
// The front queue holds two words; the core stalls while the result register is full.
module spindle_speed_map_ramp_controller #(
    parameter int MAP_POINTS = ssmr_pkg::MAP_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_action,
    input  logic [1:0]                          s_command_mode,
    input  logic [15:0]                         s_target_rpm,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [15:0]                         m_pwm_level,
    output logic [6:0]                          m_duty_now,
    output logic                                m_direction_out,
    output logic                                m_brake_out,
    output logic                                m_ramp_busy,
    output logic [1:0]                          m_mode_now,
    output logic [31:0]                         m_turns,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssmr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ssmr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ssmr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PT_IDX_W = (MAP_POINTS > 1) ? $clog2(MAP_POINTS) : 1;

    logic [2:0]                       map_count_reg;
    logic [ssmr_pkg::MS_W-1:0]        spinup_reg;
    logic [ssmr_pkg::MS_W-1:0]        spindown_reg;
    logic [ssmr_pkg::PT_W-1:0]        pt_mem [MAP_POINTS];
    logic [MAP_POINTS-1:0]            pt_valid_reg;
    logic [ssmr_pkg::PT_W-1:0]        pt_core_data_reg;
    logic                             pt_core_vld_reg;
    logic [ssmr_pkg::PT_W-1:0]        pt_apb_data_reg;
    logic                             pt_apb_vld_reg;

    logic [ssmr_pkg::REG_IDX_W-1:0]   reg_idx;
    logic [ssmr_pkg::REG_IDX_W-1:0]   pt_off;
    logic                             pt_in_range;
    logic [PT_IDX_W-1:0]              apb_pt_addr;
    logic                             wr_en;

    ssmr_pkg::item_t                  q_item;
    logic                             q_valid;
    logic                             q_pop;
    ssmr_pkg::cfg_t                   cfg;
    logic [PT_IDX_W-1:0]              pt_addr;
    logic [ssmr_pkg::PT_W-1:0]        pt_rdata;
    ssmr_pkg::res_t                   res;

    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite;
    assign reg_idx     = paddr[ssmr_pkg::APB_ADDR_W-1:2];
    assign pt_off      = reg_idx - ssmr_pkg::REG_POINT0;
    assign pt_in_range = (reg_idx >= ssmr_pkg::REG_POINT0) &&
                         (pt_off < ssmr_pkg::REG_IDX_W'(MAP_POINTS));
    assign apb_pt_addr = pt_in_range ? pt_off[PT_IDX_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_count_reg   <= '0;
            spinup_reg      <= ssmr_pkg::SPINUP_RST;
            spindown_reg    <= ssmr_pkg::SPINDOWN_RST;
            pt_valid_reg    <= '0;
            pt_core_vld_reg <= 1'b0;
            pt_apb_vld_reg  <= 1'b0;
        end else begin
            pt_core_vld_reg <= pt_valid_reg[pt_addr];
            pt_apb_vld_reg  <= pt_valid_reg[apb_pt_addr] && pt_in_range;
            if (wr_en) begin
                case (reg_idx)
                    ssmr_pkg::REG_MAP_COUNT: map_count_reg <= pwdata[2:0];
                    ssmr_pkg::REG_SPINUP:    spinup_reg    <= pwdata[15:0];
                    ssmr_pkg::REG_SPINDOWN:  spindown_reg  <= pwdata[15:0];
                    default: begin
                        if (pt_in_range) begin
                            pt_valid_reg[apb_pt_addr] <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // map point store: one write port, registered reads for the core and the APB side
    always_ff @(posedge aclk) begin
        if (wr_en && pt_in_range) begin
            pt_mem[apb_pt_addr] <= pwdata[ssmr_pkg::PT_W-1:0];
        end
        pt_core_data_reg <= pt_mem[pt_addr];
        pt_apb_data_reg  <= pt_mem[apb_pt_addr];
    end

    assign pt_rdata = pt_core_vld_reg ? pt_core_data_reg : '0;

    always_comb begin
        case (reg_idx)
            ssmr_pkg::REG_MAP_COUNT: prdata = ssmr_pkg::APB_DATA_W'(map_count_reg);
            ssmr_pkg::REG_SPINUP:    prdata = ssmr_pkg::APB_DATA_W'(spinup_reg);
            ssmr_pkg::REG_SPINDOWN:  prdata = ssmr_pkg::APB_DATA_W'(spindown_reg);
            default: prdata = pt_apb_vld_reg ? ssmr_pkg::APB_DATA_W'(pt_apb_data_reg) : '0;
        endcase
    end

    assign cfg = '{map_count: map_count_reg, spinup_ms: spinup_reg, spindown_ms: spindown_reg};

    ssmr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_command_mode (s_command_mode),
        .s_target_rpm   (s_target_rpm),
        .q_item         (q_item),
        .q_valid        (q_valid),
        .q_pop          (q_pop)
    );

    ssmr_core #(
        .MAP_POINTS (MAP_POINTS),
        .PT_IDX_W   (PT_IDX_W)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .pt_addr  (pt_addr),
        .pt_rdata (pt_rdata),
        .m_res    (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

    assign m_pwm_level     = res.pwm_level;
    assign m_duty_now      = res.duty_now;
    assign m_direction_out = res.direction_out;
    assign m_brake_out     = res.brake_out;
    assign m_ramp_busy     = res.ramp_busy;
    assign m_mode_now      = res.mode_now;
    assign m_turns         = res.turns;

endmodule
